// File: rtl/atcp_pkg.sv
// Shared types and constants for the ANSI text console parser.
`timescale 1ns / 1ps

package atcp_pkg;

  // Parser mode
  typedef enum logic [1:0] {
    MODE_IDLE = 2'd0,
    MODE_ESC  = 2'd1,
    MODE_CSI  = 2'd2
  } atcp_mode_t;

  // Command kinds
  localparam logic CMD_GLYPH  = 1'b0;
  localparam logic CMD_SCROLL = 1'b1;

  // Register indexes (paddr[3:2])
  localparam logic [1:0] REG_TEXT_COLUMNS  = 2'd0;
  localparam logic [1:0] REG_TEXT_ROWS     = 2'd1;
  localparam logic [1:0] REG_HIGHEST_GLYPH = 2'd2;
  localparam logic [1:0] REG_SCROLL_LINES  = 2'd3;

  localparam int ADDR_W = 4;

  // Register reset values
  localparam logic [8:0] RST_TEXT_COLUMNS  = 9'd80;
  localparam logic [7:0] RST_TEXT_ROWS     = 8'd25;
  localparam logic [7:0] RST_HIGHEST_GLYPH = 8'd127;
  localparam logic [7:0] RST_SCROLL_LINES  = 8'd1;

  // Result queue geometry
  localparam int QDEPTH = 4;
  localparam int QPTR_W = 2;
  localparam int QCNT_W = 3;

  // One command word
  typedef struct packed {
    logic       cmd_kind;
    logic [7:0] glyph_code;
    logic [7:0] cell_col;
    logic [6:0] cell_row;
    logic [3:0] fg_color;
    logic [3:0] bg_color;
    logic       last_cmd;
  } atcp_cmd_t;

  // Register file contents
  typedef struct packed {
    logic [8:0] text_columns;
    logic [7:0] text_rows;
    logic [7:0] highest_glyph;
    logic [7:0] scroll_lines;
  } atcp_cfg_t;

  // Up to two commands produced by one byte
  typedef struct packed {
    logic [1:0] cmd_cnt;
    atcp_cmd_t  cmd0;
    atcp_cmd_t  cmd1;
  } atcp_emit_t;

endpackage

// File: rtl/atcp_if.sv
// Stream interfaces for text bytes in and cell commands out.
`timescale 1ns / 1ps

interface atcp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

interface atcp_cmd_if;
  logic       valid;
  logic       ready;
  logic       cmd_kind;
  logic [7:0] glyph_code;
  logic [7:0] cell_col;
  logic [6:0] cell_row;
  logic [3:0] fg_color;
  logic [3:0] bg_color;
  logic       last_cmd;

  modport source (output valid, output cmd_kind, output glyph_code, output cell_col,
                  output cell_row, output fg_color, output bg_color, output last_cmd,
                  input ready);
  modport sink   (input valid, input cmd_kind, input glyph_code, input cell_col,
                  input cell_row, input fg_color, input bg_color, input last_cmd,
                  output ready);
endinterface

// File: rtl/atcp_core.sv
// Escape parser, SGR/CUP folding, cursor tracking and command generation.
`timescale 1ns / 1ps

module atcp_core import atcp_pkg::*; #(
  parameter int SEQ_BUF_DEPTH = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       item_vld,
  input  logic [7:0] item_byte,
  input  atcp_cfg_t  cfg,
  output atcp_emit_t emit
);

  localparam int SEQ_W = $clog2(SEQ_BUF_DEPTH + 1);
  localparam logic [SEQ_W-1:0] SEQ_FULL = SEQ_W'(SEQ_BUF_DEPTH);
  localparam logic [SEQ_W-1:0] SEQ_ONE  = SEQ_W'(1);

  localparam logic [7:0] CH_ESC   = 8'h1B;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_LBRK  = 8'h5B;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_QMARK = 8'h3F;
  localparam logic [7:0] CH_M     = 8'h6D;
  localparam logic [7:0] CH_H     = 8'h48;
  localparam logic [7:0] FINAL_LO = 8'h40;
  localparam logic [7:0] FINAL_HI = 8'h7E;
  localparam logic [9:0] VALUE_MAX = 10'd1023;
  localparam logic [3:0] FG_DEFAULT = 4'hF;
  localparam logic [3:0] BG_DEFAULT = 4'h0;

  // SGR field applied to the pending colors; returns {fg, bg}
  function automatic logic [7:0] sgr_apply(input logic [9:0] v, input logic [1:0] chars,
                                           input logic fz, input logic [3:0] pfg,
                                           input logic [3:0] pbg);
    logic [3:0] fg;
    logic [3:0] bg;
    fg = pfg;
    bg = pbg;
    if (chars == 2'd0 || (chars == 2'd1 && fz)) begin
      fg = FG_DEFAULT;
      bg = BG_DEFAULT;
    end else if (v >= 10'd30 && v <= 10'd37) begin
      fg = 4'(v - 10'd30);
    end else if (v >= 10'd40 && v <= 10'd47) begin
      bg = 4'(v - 10'd40);
    end else if (v >= 10'd90 && v <= 10'd97) begin
      fg = 4'(v - 10'd90);
    end else if (v >= 10'd100 && v <= 10'd107) begin
      bg = 4'(v - 10'd100);
    end
    return {fg, bg};
  endfunction

  // State
  atcp_mode_t       mode_r, mode_nxt;
  logic [SEQ_W-1:0] seq_cnt_r, seq_cnt_nxt;
  logic [9:0]       pval_r, pval_nxt;
  logic [1:0]       pchars_r, pchars_nxt;
  logic             pfz_r, pfz_nxt;
  logic             dend_r, dend_nxt;
  logic             nul_r, nul_nxt;
  logic             cup_row_r, cup_row_nxt;
  logic [3:0]       pfg_r, pfg_nxt;
  logic [3:0]       pbg_r, pbg_nxt;
  logic [6:0]       prow_r, prow_nxt;
  logic [7:0]       pcol_r, pcol_nxt;
  logic [7:0]       ccol_r, ccol_nxt;
  logic [6:0]       crow_r, crow_nxt;
  logic [3:0]       fg_r, fg_nxt;
  logic [3:0]       bg_r, bg_nxt;

  // Effective screen geometry
  logic [8:0] cols_eff;
  logic [7:0] rows_eff;
  logic [7:0] scr_eff;
  logic [7:0] cols_m1;
  logic [6:0] rows_m1;

  always_comb begin
    priority if (cfg.text_columns == 9'd0) cols_eff = 9'd1;
    else if (cfg.text_columns > 9'd256)     cols_eff = 9'd256;
    else                                    cols_eff = cfg.text_columns;
    priority if (cfg.text_rows == 8'd0) rows_eff = 8'd1;
    else if (cfg.text_rows > 8'd128)     rows_eff = 8'd128;
    else                                 rows_eff = cfg.text_rows;
    priority if (cfg.scroll_lines == 8'd0) scr_eff = 8'd1;
    else if (cfg.scroll_lines > rows_eff)   scr_eff = rows_eff;
    else                                    scr_eff = cfg.scroll_lines;
  end

  assign cols_m1 = 8'(cols_eff - 9'd1);
  assign rows_m1 = 7'(rows_eff - 8'd1);

  // Byte classes
  logic [SEQ_W-1:0] seq_inc;
  logic             is_final;
  logic             is_digit;
  logic [13:0]      val_acc;
  logic [9:0]       val_dig;

  assign seq_inc  = seq_cnt_r + SEQ_ONE;
  assign is_final = (item_byte >= FINAL_LO) && (item_byte <= FINAL_HI);
  assign is_digit = (item_byte >= CH_ZERO) && (item_byte <= CH_NINE);
  assign val_acc  = 14'(pval_r) * 14'd10 + 14'(item_byte - CH_ZERO);
  assign val_dig  = (val_acc > 14'(VALUE_MAX)) ? VALUE_MAX : val_acc[9:0];

  // CUP field: 1-based value to 0-based row or column
  logic [9:0] cup_v;
  logic [6:0] cup_prow;
  logic [7:0] cup_pcol;
  logic [7:0] sgr_res;

  assign cup_v    = (pval_r != 10'd0) ? (pval_r - 10'd1) : 10'd0;
  assign cup_prow = !cup_row_r ? prow_r : ((cup_v > 10'd127) ? 7'd127 : cup_v[6:0]);
  assign cup_pcol = cup_row_r ? pcol_r : ((cup_v > 10'd255) ? 8'd255 : cup_v[7:0]);
  assign sgr_res  = sgr_apply(pval_r, pchars_r, pfz_r, pfg_r, pbg_r);

  // Printing: clamped cursor, wrap and scroll decisions
  logic [7:0] cc;
  logic [6:0] cr;
  logic [8:0] col_inc;
  logic       wrap;
  logic       at_bottom;
  logic [6:0] nl_row;
  logic [7:0] glyph;
  atcp_cmd_t  glyph_cmd;
  atcp_cmd_t  scroll_cmd;

  assign cc        = (ccol_r > cols_m1) ? cols_m1 : ccol_r;
  assign cr        = (crow_r > rows_m1) ? rows_m1 : crow_r;
  assign col_inc   = {1'b0, cc} + 9'd1;
  assign wrap      = col_inc >= cols_eff;
  assign at_bottom = ({1'b0, cr} + 8'd1) >= rows_eff;
  assign nl_row    = at_bottom ? 7'(rows_eff - scr_eff) : 7'(cr + 7'd1);
  assign glyph     = (item_byte > cfg.highest_glyph) ? CH_QMARK : item_byte;

  always_comb begin
    glyph_cmd            = '0;
    glyph_cmd.cmd_kind   = CMD_GLYPH;
    glyph_cmd.glyph_code = glyph;
    glyph_cmd.cell_col   = cc;
    glyph_cmd.cell_row   = cr;
    glyph_cmd.fg_color   = fg_r;
    glyph_cmd.bg_color   = bg_r;
    glyph_cmd.last_cmd   = !(wrap && at_bottom);
    scroll_cmd           = '0;
    scroll_cmd.cmd_kind  = CMD_SCROLL;
    scroll_cmd.fg_color  = fg_r;
    scroll_cmd.bg_color  = bg_r;
    scroll_cmd.last_cmd  = 1'b1;
  end

  // Next state and commands for the byte in the input register
  always_comb begin
    mode_nxt    = mode_r;
    seq_cnt_nxt = seq_cnt_r;
    pval_nxt    = pval_r;
    pchars_nxt  = pchars_r;
    pfz_nxt     = pfz_r;
    dend_nxt    = dend_r;
    nul_nxt     = nul_r;
    cup_row_nxt = cup_row_r;
    pfg_nxt     = pfg_r;
    pbg_nxt     = pbg_r;
    prow_nxt    = prow_r;
    pcol_nxt    = pcol_r;
    ccol_nxt    = ccol_r;
    crow_nxt    = crow_r;
    fg_nxt      = fg_r;
    bg_nxt      = bg_r;
    emit        = '0;

    if (item_vld) begin
      unique case (mode_r)
        MODE_ESC: begin
          if (item_byte == CH_LBRK) begin
            mode_nxt    = MODE_CSI;
            seq_cnt_nxt = '0;
            pval_nxt    = '0;
            pchars_nxt  = '0;
            pfz_nxt     = 1'b0;
            dend_nxt    = 1'b0;
            nul_nxt     = 1'b0;
            cup_row_nxt = 1'b1;
            pfg_nxt     = fg_r;
            pbg_nxt     = bg_r;
            prow_nxt    = crow_r;
            pcol_nxt    = ccol_r;
          end else begin
            mode_nxt = MODE_IDLE;
          end
        end

        MODE_CSI: begin
          seq_cnt_nxt = seq_inc;
          if (is_final) begin
            mode_nxt = MODE_IDLE;
            if (item_byte == CH_M) begin
              if (seq_inc == SEQ_ONE) begin
                fg_nxt = FG_DEFAULT;
                bg_nxt = BG_DEFAULT;
              end else if (pchars_r != 2'd0) begin
                {pfg_nxt, pbg_nxt} = sgr_res;
                {fg_nxt, bg_nxt}   = sgr_res;
              end else begin
                fg_nxt = pfg_r;
                bg_nxt = pbg_r;
              end
            end else if (item_byte == CH_H) begin
              prow_nxt    = cup_prow;
              pcol_nxt    = cup_pcol;
              cup_row_nxt = !cup_row_r;
              crow_nxt    = (cup_prow > rows_m1) ? rows_m1 : cup_prow;
              ccol_nxt    = (cup_pcol > cols_m1) ? cols_m1 : cup_pcol;
            end
          end else if (seq_inc >= SEQ_FULL) begin
            // sequence buffer full: drop it
            mode_nxt = MODE_IDLE;
          end else if (!nul_r) begin
            if (item_byte == CH_NUL) begin
              nul_nxt = 1'b1;
            end else if (item_byte == CH_SEMI) begin
              {pfg_nxt, pbg_nxt} = sgr_res;
              prow_nxt    = cup_prow;
              pcol_nxt    = cup_pcol;
              cup_row_nxt = !cup_row_r;
              pval_nxt    = '0;
              pchars_nxt  = '0;
              pfz_nxt     = 1'b0;
              dend_nxt    = 1'b0;
            end else begin
              if (pchars_r == 2'd0) pfz_nxt = (item_byte == CH_ZERO);
              if (pchars_r != 2'd2) pchars_nxt = pchars_r + 2'd1;
              if (!dend_r && is_digit) pval_nxt = val_dig;
              else                     dend_nxt = 1'b1;
            end
          end
        end

        default: begin
          if (item_byte == CH_ESC) begin
            mode_nxt = MODE_ESC;
          end else if (item_byte == CH_LF) begin
            ccol_nxt = 8'd0;
            crow_nxt = nl_row;
            if (at_bottom) begin
              emit.cmd_cnt = 2'd1;
              emit.cmd0    = scroll_cmd;
            end
          end else begin
            emit.cmd_cnt = 2'd1;
            emit.cmd0    = glyph_cmd;
            if (wrap) begin
              ccol_nxt = 8'd0;
              crow_nxt = nl_row;
              if (at_bottom) begin
                emit.cmd_cnt = 2'd2;
                emit.cmd1    = scroll_cmd;
              end
            end else begin
              ccol_nxt = col_inc[7:0];
              crow_nxt = cr;
            end
          end
        end
      endcase
    end
  end

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= MODE_IDLE;
      seq_cnt_r <= '0;
      pval_r    <= '0;
      pchars_r  <= '0;
      pfz_r     <= 1'b0;
      dend_r    <= 1'b0;
      nul_r     <= 1'b0;
      cup_row_r <= 1'b1;
      pfg_r     <= FG_DEFAULT;
      pbg_r     <= BG_DEFAULT;
      prow_r    <= '0;
      pcol_r    <= '0;
      ccol_r    <= '0;
      crow_r    <= '0;
      fg_r      <= FG_DEFAULT;
      bg_r      <= BG_DEFAULT;
    end else begin
      mode_r    <= mode_nxt;
      seq_cnt_r <= seq_cnt_nxt;
      pval_r    <= pval_nxt;
      pchars_r  <= pchars_nxt;
      pfz_r     <= pfz_nxt;
      dend_r    <= dend_nxt;
      nul_r     <= nul_nxt;
      cup_row_r <= cup_row_nxt;
      pfg_r     <= pfg_nxt;
      pbg_r     <= pbg_nxt;
      prow_r    <= prow_nxt;
      pcol_r    <= pcol_nxt;
      ccol_r    <= ccol_nxt;
      crow_r    <= crow_nxt;
      fg_r      <= fg_nxt;
      bg_r      <= bg_nxt;
    end
  end

  // Escape and sequence bytes never draw
  a_no_cmd_in_seq: assert property (@(posedge clk) disable iff (!rst_n)
    item_vld && (mode_r == MODE_ESC || mode_r == MODE_CSI) |-> emit.cmd_cnt == 2'd0)
    else $error("command emitted inside an escape sequence");

  // A second command is only ever the scroll after a wrapping glyph
  a_pair_order: assert property (@(posedge clk) disable iff (!rst_n)
    emit.cmd_cnt == 2'd2 |-> emit.cmd0.cmd_kind == CMD_GLYPH &&
                             emit.cmd1.cmd_kind == CMD_SCROLL && !emit.cmd0.last_cmd)
    else $error("bad command pair");

  // Cursor position committed by CUP lies on screen
  a_cup_clamped: assert property (@(posedge clk) disable iff (!rst_n)
    item_vld && mode_r == MODE_CSI && item_byte == CH_H |=>
      crow_r <= $past(rows_m1) && ccol_r <= $past(cols_m1))
    else $error("CUP left cursor off screen");

endmodule

// File: rtl/atcp_outq.sv
// Four-word command queue taking up to two words per cycle.
`timescale 1ns / 1ps

module atcp_outq import atcp_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  atcp_emit_t emit,
  input  logic       pop,
  output logic       space,
  output logic       head_vld,
  output atcp_cmd_t  head
);

  atcp_cmd_t          q_r [QDEPTH];
  logic [QPTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0]  cnt_r, cnt_nxt;
  logic [QPTR_W-1:0]  wr_ptr_p1;
  logic               do_pop;

  // Room for the two words a byte can produce
  assign space     = cnt_r <= QCNT_W'(QDEPTH - 2);
  assign head_vld  = cnt_r != '0;
  assign head      = q_r[rd_ptr_r];
  assign do_pop    = pop && head_vld;
  assign wr_ptr_p1 = wr_ptr_r + QPTR_W'(1);

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + QPTR_W'(emit.cmd_cnt);
    rd_ptr_nxt = rd_ptr_r + QPTR_W'(do_pop);
    cnt_nxt    = cnt_r + QCNT_W'(emit.cmd_cnt) - QCNT_W'(do_pop);
  end

  // Payload storage
  always_ff @(posedge clk) begin
    if (emit.cmd_cnt != 2'd0) q_r[wr_ptr_r] <= emit.cmd0;
    if (emit.cmd_cnt == 2'd2) q_r[wr_ptr_p1] <= emit.cmd1;
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    emit.cmd_cnt != 2'd0 |-> space)
    else $error("command queue written without room");

  a_fill_tracks_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= QCNT_W'(QDEPTH) &&
    (wr_ptr_r - rd_ptr_r) == cnt_r[QPTR_W-1:0])
    else $error("queue fill count out of step with pointers");

endmodule

// File: rtl/ansi_text_console_parser_unit.sv
// Top level: byte input register, register file, parser core and command queue.
`timescale 1ns / 1ps
//
//  Channel   Dir  Handshake            Word
//  in_ch     in   valid/ready          in_byte: one text byte
//  out_ch    out  valid/ready          glyph or scroll command
//  APB       in   psel/penable/pready  4 config registers at 0x0, 0x4, 0x8, 0xC
//
//  One byte accepted per cycle while the queue has room. A byte waits in the
//  input register, and its commands are then written to the command queue. A byte
//  that wraps at the bottom row yields two words; out_ch drains one per cycle
//  while ready is high. A held byte waits while the queue has fewer than two
//  free words, and the input stalls behind it. Synchronous reset restores the
//  control state and config registers; byte and queue payloads are not reset.

module ansi_text_console_parser_unit import atcp_pkg::*; #(
  parameter int SEQ_BUF_DEPTH = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  atcp_byte_if.sink         in_ch,
  atcp_cmd_if.source        out_ch,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  // Register file
  atcp_cfg_t cfg_r;
  logic      reg_wr;

  assign pready = 1'b1;
  assign reg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.text_columns  <= RST_TEXT_COLUMNS;
      cfg_r.text_rows     <= RST_TEXT_ROWS;
      cfg_r.highest_glyph <= RST_HIGHEST_GLYPH;
      cfg_r.scroll_lines  <= RST_SCROLL_LINES;
    end else if (reg_wr) begin
      unique case (paddr[3:2])
        REG_TEXT_COLUMNS:  cfg_r.text_columns  <= pwdata[8:0];
        REG_TEXT_ROWS:     cfg_r.text_rows     <= pwdata[7:0];
        REG_HIGHEST_GLYPH: cfg_r.highest_glyph <= pwdata[7:0];
        REG_SCROLL_LINES:  cfg_r.scroll_lines  <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  // Register readback
  always_comb begin
    unique case (paddr[3:2])
      REG_TEXT_COLUMNS:  prdata = {23'd0, cfg_r.text_columns};
      REG_TEXT_ROWS:     prdata = {24'd0, cfg_r.text_rows};
      REG_HIGHEST_GLYPH: prdata = {24'd0, cfg_r.highest_glyph};
      REG_SCROLL_LINES:  prdata = {24'd0, cfg_r.scroll_lines};
      default:           prdata = '0;
    endcase
  end

  // Input register
  logic [7:0] byte_r;
  logic       byte_vld_r, byte_vld_nxt;
  logic       in_acc;
  logic       fire;
  logic       q_space;

  assign fire         = byte_vld_r && q_space;
  assign in_ch.ready  = !byte_vld_r || fire;
  assign in_acc       = in_ch.valid && in_ch.ready;
  assign byte_vld_nxt = in_acc || (byte_vld_r && !fire);

  always_ff @(posedge clk) begin
    if (in_acc) byte_r <= in_ch.in_byte;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) byte_vld_r <= 1'b0;
    else        byte_vld_r <= byte_vld_nxt;
  end

  // Parser core
  atcp_emit_t emit;

  atcp_core #(
    .SEQ_BUF_DEPTH(SEQ_BUF_DEPTH)
  ) u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .item_vld (fire),
    .item_byte(byte_r),
    .cfg      (cfg_r),
    .emit     (emit)
  );

  // Command queue
  atcp_cmd_t head;
  logic      head_vld;

  atcp_outq u_outq (
    .clk     (clk),
    .rst_n   (rst_n),
    .emit    (emit),
    .pop     (out_ch.ready),
    .space   (q_space),
    .head_vld(head_vld),
    .head    (head)
  );

  assign out_ch.valid      = head_vld;
  assign out_ch.cmd_kind   = head.cmd_kind;
  assign out_ch.glyph_code = head.glyph_code;
  assign out_ch.cell_col   = head.cell_col;
  assign out_ch.cell_row   = head.cell_row;
  assign out_ch.fg_color   = head.fg_color;
  assign out_ch.bg_color   = head.bg_color;
  assign out_ch.last_cmd   = head.last_cmd;

  // A held byte is never dropped or overwritten
  a_hold_byte: assert property (@(posedge clk) disable iff (!rst_n)
    byte_vld_r && !fire |=> byte_vld_r && $stable(byte_r))
    else $error("stalled input byte lost");

endmodule

// File: tb/sv/ansi_text_console_parser_unit_tb.sv
// Self-checking bench for the ANSI text console parser: byte stream in, cell command words out.
`timescale 1ns / 1ps

module ansi_text_console_parser_unit_tb;
  import atcp_pkg::*;

  localparam int HALF_PERIOD  = 6;
  localparam int RESET_CYCLES = 12;
  localparam int SEQ_DEPTH    = 16;
  localparam int DRAIN_SETTLE = 8;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int MAX_REPORTS  = 40;

  // Byte codes the parser reacts to
  localparam logic [7:0] CH_NUL      = 8'h00;
  localparam logic [7:0] CH_NL       = 8'h0A;
  localparam logic [7:0] CH_ESC      = 8'h1B;
  localparam logic [7:0] CH_ZERO     = 8'h30;
  localparam logic [7:0] CH_NINE     = 8'h39;
  localparam logic [7:0] CH_SEP      = 8'h3B;
  localparam logic [7:0] CH_QMARK    = 8'h3F;
  localparam logic [7:0] CH_FINAL_LO = 8'h40;
  localparam logic [7:0] CH_CUP      = 8'h48;
  localparam logic [7:0] CH_CSI_OPEN = 8'h5B;
  localparam logic [7:0] CH_SGR      = 8'h6D;
  localparam logic [7:0] CH_FINAL_HI = 8'h7E;
  localparam logic [7:0] CH_ABORT    = 8'h78;
  localparam logic [7:0] CH_LETTER   = 8'h41;

  localparam int FG_DEFAULT = 15;
  localparam int BG_DEFAULT = 0;
  localparam int VALUE_SAT  = 1023;

  logic clk = 1'b0;
  logic rst_n;
  logic psel, penable, pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic pready;

  atcp_byte_if in_ch();
  atcp_cmd_if  out_ch();

  ansi_text_console_parser_unit #(.SEQ_BUF_DEPTH(SEQ_DEPTH)) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  always #HALF_PERIOD clk = ~clk;

  // Screen registers as the parser should see them
  int reg_cols       = RST_TEXT_COLUMNS;
  int reg_rows       = RST_TEXT_ROWS;
  int reg_glyph_max  = RST_HIGHEST_GLYPH;
  int reg_scroll     = RST_SCROLL_LINES;

  // Parser and cursor state of the predictor
  atcp_mode_t parse_state = MODE_IDLE;
  int csi_len = 0;
  int fld_value = 0;
  int fld_chars = 0;
  bit fld_lead_zero = 0;
  bit fld_text_over = 0;
  bit csi_nul = 0;
  bit cup_next_row = 1;
  int sgr_fg = FG_DEFAULT;
  int sgr_bg = BG_DEFAULT;
  int cup_row = 0;
  int cup_col = 0;
  int cur_col = 0;
  int cur_row = 0;
  int cur_fg = FG_DEFAULT;
  int cur_bg = BG_DEFAULT;

  atcp_cmd_t cell_cmds_due[$];
  atcp_cmd_t step_cmds[$];
  logic [7:0] chunk[$];

  int mismatch_count = 0;
  int cycle_count = 0;
  int burst_left = 0;
  bit sender_steady = 0;
  int ready_mode = 0;
  int ready_span = 0;
  int ready_tick = 0;

  // ---------------------------------------------------------------- predictor

  function automatic int screen_cols();
    if (reg_cols < 1) return 1;
    if (reg_cols > 256) return 256;
    return reg_cols;
  endfunction

  function automatic int screen_rows();
    if (reg_rows < 1) return 1;
    if (reg_rows > 128) return 128;
    return reg_rows;
  endfunction

  function automatic void clamp_cursor();
    if (cur_col > screen_cols() - 1) cur_col = screen_cols() - 1;
    if (cur_row > screen_rows() - 1) cur_row = screen_rows() - 1;
  endfunction

  function automatic void clear_fld();
    fld_value = 0;
    fld_chars = 0;
    fld_lead_zero = 0;
    fld_text_over = 0;
  endfunction

  function automatic atcp_cmd_t make_cmd(input logic kind, input int glyph, input int col,
                                         input int row);
    atcp_cmd_t w;
    w.cmd_kind   = kind;
    w.glyph_code = glyph[7:0];
    w.cell_col   = col[7:0];
    w.cell_row   = row[6:0];
    w.fg_color   = cur_fg[3:0];
    w.bg_color   = cur_bg[3:0];
    w.last_cmd   = 1'b0;
    return w;
  endfunction

  // Carriage to column 0, next row; scroll when leaving the bottom row
  function automatic void line_feed();
    int rows, span;
    rows = screen_rows();
    span = (reg_scroll < 1) ? 1 : reg_scroll;
    if (span > rows) span = rows;
    cur_col = 0;
    if (cur_row + 1 >= rows) begin
      step_cmds.push_back(make_cmd(CMD_SCROLL, 0, 0, 0));
      cur_row = rows - span;
    end else begin
      cur_row++;
    end
  endfunction

  // One SGR field into the pending colors
  function automatic void sgr_apply();
    if (fld_chars == 0 || (fld_chars == 1 && fld_lead_zero)) begin
      sgr_fg = FG_DEFAULT;
      sgr_bg = BG_DEFAULT;
    end else if (fld_value >= 30 && fld_value <= 37) begin
      sgr_fg = fld_value - 30;
    end else if (fld_value >= 40 && fld_value <= 47) begin
      sgr_bg = fld_value - 40;
    end else if (fld_value >= 90 && fld_value <= 97) begin
      sgr_fg = fld_value - 90;
    end else if (fld_value >= 100 && fld_value <= 107) begin
      sgr_bg = fld_value - 100;
    end
  endfunction

  // One cursor field: row and column alternate, 1-based
  function automatic void cup_apply();
    int v;
    v = (fld_value != 0) ? fld_value - 1 : 0;
    if (cup_next_row) cup_row = (v > 127) ? 127 : v;
    else cup_col = (v > 255) ? 255 : v;
    cup_next_row = !cup_next_row;
  endfunction

  function automatic void csi_param(input logic [7:0] c);
    if (csi_nul) return;
    if (c == CH_NUL) begin
      csi_nul = 1;
      return;
    end
    if (c == CH_SEP) begin
      sgr_apply();
      cup_apply();
      clear_fld();
      return;
    end
    if (fld_chars == 0) fld_lead_zero = (c == CH_ZERO);
    if (fld_chars < 2) fld_chars++;
    if (!fld_text_over && c >= CH_ZERO && c <= CH_NINE) begin
      fld_value = fld_value * 10 + (c - CH_ZERO);
      if (fld_value > VALUE_SAT) fld_value = VALUE_SAT;
    end else begin
      fld_text_over = 1;
    end
  endfunction

  // Advance the console by one byte and queue the words it should produce
  function automatic void console_step(input logic [7:0] c);
    atcp_cmd_t w;
    step_cmds.delete();
    case (parse_state)
      MODE_ESC: begin
        if (c == CH_CSI_OPEN) begin
          parse_state = MODE_CSI;
          csi_len = 0;
          clear_fld();
          csi_nul = 0;
          cup_next_row = 1;
          sgr_fg = cur_fg;
          sgr_bg = cur_bg;
          cup_row = cur_row;
          cup_col = cur_col;
        end else begin
          parse_state = MODE_IDLE;
        end
      end
      MODE_CSI: begin
        csi_len++;
        if (c >= CH_FINAL_LO && c <= CH_FINAL_HI) begin
          if (c == CH_SGR) begin
            if (csi_len == 1) begin
              cur_fg = FG_DEFAULT;
              cur_bg = BG_DEFAULT;
            end else begin
              if (fld_chars != 0) sgr_apply();
              cur_fg = sgr_fg;
              cur_bg = sgr_bg;
            end
          end else if (c == CH_CUP) begin
            cup_apply();
            cur_row = cup_row;
            cur_col = cup_col;
            clamp_cursor();
          end
          parse_state = MODE_IDLE;
        end else if (csi_len >= SEQ_DEPTH) begin
          parse_state = MODE_IDLE;
        end else begin
          csi_param(c);
        end
      end
      default: begin
        if (c == CH_ESC) begin
          parse_state = MODE_ESC;
        end else begin
          clamp_cursor();
          if (c == CH_NL) begin
            line_feed();
          end else begin
            step_cmds.push_back(make_cmd(CMD_GLYPH, (c > reg_glyph_max) ? CH_QMARK : c,
                                         cur_col, cur_row));
            cur_col++;
            if (cur_col >= screen_cols()) line_feed();
          end
        end
      end
    endcase
    if (step_cmds.size() > 0) begin
      w = step_cmds.pop_back();
      w.last_cmd = 1'b1;
      step_cmds.push_back(w);
    end
    foreach (step_cmds[i]) cell_cmds_due.push_back(step_cmds[i]);
  endfunction

  // ---------------------------------------------------------------- checking

  function automatic void check_field(input string field, input logic [7:0] want_v,
                                      input logic [7:0] got_v);
    if (got_v !== want_v) begin
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS)
        $display("%0t: %s mismatch, expected %0h, got %0h", $time, field, want_v, got_v);
    end
  endfunction

  // Compare each accepted word with the oldest expectation
  always @(posedge clk) begin
    atcp_cmd_t want;
    if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      if (cell_cmds_due.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
          $display("%0t: unexpected word, expected none, got kind %0h glyph %0h col %0h row %0h",
                   $time, out_ch.cmd_kind, out_ch.glyph_code, out_ch.cell_col,
                   out_ch.cell_row);
      end else begin
        want = cell_cmds_due.pop_front();
        check_field("cmd_kind", want.cmd_kind, out_ch.cmd_kind);
        check_field("glyph_code", want.glyph_code, out_ch.glyph_code);
        check_field("cell_col", want.cell_col, out_ch.cell_col);
        check_field("cell_row", want.cell_row, out_ch.cell_row);
        check_field("fg_color", want.fg_color, out_ch.fg_color);
        check_field("bg_color", want.bg_color, out_ch.bg_color);
        check_field("last_cmd", want.last_cmd, out_ch.last_cmd);
      end
    end
  end

  // Run watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Receiver backpressure: spans of always-ready, random and periodic stalls
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (ready_span == 0) begin
        ready_mode = $urandom_range(0, 3);
        ready_span = $urandom_range(20, 150);
      end
      ready_span--;
      ready_tick++;
      case (ready_mode)
        0: out_ch.ready <= 1'b1;
        1: out_ch.ready <= ($urandom_range(0, 1) == 1);
        2: out_ch.ready <= ((ready_tick % 4) != 3);
        default: out_ch.ready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  // ---------------------------------------------------------------- drivers

  // Send one byte, with a random gap at the start of each burst unless the sender is steady
  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = 0;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if (!sender_steady) gap = $urandom_range(0, 5);
    end
    burst_left--;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.in_byte <= b;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    console_step(b);
  endtask

  task automatic send_chunk();
    foreach (chunk[i]) send_byte(chunk[i]);
    chunk.delete();
  endtask

  // Hold input off until every expected word has come out
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (cell_cmds_due.size() != 0) @(posedge clk);
    repeat (DRAIN_SETTLE) @(posedge clk);
    burst_left = 0;
  endtask

  // Register write: setup phase, access phase, then the bus goes idle
  task automatic write_reg(input logic [1:0] idx, input int value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_TEXT_COLUMNS:  reg_cols      = value & 'h1FF;
      REG_TEXT_ROWS:     reg_rows      = value & 'hFF;
      REG_HIGHEST_GLYPH: reg_glyph_max = value & 'hFF;
      default:           reg_scroll    = value & 'hFF;
    endcase
    @(posedge clk);
  endtask

  // ---------------------------------------------------------------- stimulus

  function automatic void add_number(input int v, input bit lead_zero);
    string s;
    s = $sformatf("%0d", v);
    if (lead_zero) chunk.push_back(CH_ZERO);
    for (int i = 0; i < s.len(); i++) chunk.push_back(s[i]);
  endfunction

  function automatic void add_csi_open();
    chunk.push_back(CH_ESC);
    chunk.push_back(CH_CSI_OPEN);
  endfunction

  // One random piece of console text: plain text, SGR, CUP, broken sequence or noise
  function automatic void build_chunk();
    int kind, n;
    logic [7:0] b;
    kind = $urandom_range(0, 99);
    if (kind < 40) begin
      n = $urandom_range(1, 12);
      repeat (n) begin
        case ($urandom_range(0, 15))
          0: b = CH_NL;
          1: b = $urandom_range(0, 255);
          default: b = $urandom_range(8'h20, 8'h7E);
        endcase
        chunk.push_back(b);
      end
    end else if (kind < 65) begin
      add_csi_open();
      n = $urandom_range(0, 3);
      for (int f = 0; f < n; f++) begin
        if (f > 0) chunk.push_back(CH_SEP);
        case ($urandom_range(0, 7))
          0: ;
          1: chunk.push_back(CH_ZERO);
          2: add_number(30 + $urandom_range(0, 7), $urandom_range(0, 7) == 0);
          3: add_number(40 + $urandom_range(0, 7), 1'b0);
          4: add_number(90 + $urandom_range(0, 7), 1'b0);
          5: add_number(100 + $urandom_range(0, 7), 1'b0);
          6: add_number($urandom_range(0, 1100), $urandom_range(0, 3) == 0);
          default: begin
            add_number($urandom_range(0, 120), 1'b0);
            case ($urandom_range(0, 2))
              0: b = $urandom_range(8'h20, 8'h2F);
              1: b = $urandom_range(8'h80, 8'hFF);
              default: b = $urandom_range(8'h01, 8'h1F);
            endcase
            chunk.push_back(b);
            if ($urandom_range(0, 1) == 1) add_number($urandom_range(30, 47), 1'b0);
          end
        endcase
      end
      if ($urandom_range(0, 5) == 0) chunk.push_back(CH_SEP);
      chunk.push_back(CH_SGR);
    end else if (kind < 80) begin
      add_csi_open();
      n = $urandom_range(0, 3);
      for (int f = 0; f < n; f++) begin
        if (f > 0) chunk.push_back(CH_SEP);
        if ($urandom_range(0, 4) != 0)
          add_number(($urandom_range(0, 1) == 1) ? $urandom_range(0, 30)
                                                  : $urandom_range(0, 300), 1'b0);
      end
      chunk.push_back(CH_CUP);
    end else if (kind < 90) begin
      case ($urandom_range(0, 3))
        0: begin
          // escape followed by something other than a bracket
          chunk.push_back(CH_ESC);
          b = $urandom_range(0, 255);
          chunk.push_back(b);
        end
        1: begin
          // parameter text that may overrun the sequence buffer
          add_csi_open();
          repeat ($urandom_range(SEQ_DEPTH - 2, SEQ_DEPTH + 3)) begin
            b = $urandom_range(CH_ZERO, CH_SEP);
            chunk.push_back(b);
          end
          chunk.push_back(($urandom_range(0, 1) == 1) ? CH_SGR : CH_CUP);
        end
        2: begin
          // NUL ends the parameter text early
          add_csi_open();
          add_number($urandom_range(1, 47), 1'b0);
          chunk.push_back(CH_NUL);
          add_number($urandom_range(0, 110), 1'b0);
          if ($urandom_range(0, 1) == 1) chunk.push_back(CH_SEP);
          chunk.push_back(($urandom_range(0, 1) == 1) ? CH_SGR : CH_CUP);
        end
        default: begin
          // final byte drawn from the whole final range, which may also be SGR or CUP
          add_csi_open();
          add_number($urandom_range(0, 50), 1'b0);
          b = $urandom_range(CH_FINAL_LO, CH_FINAL_HI);
          chunk.push_back(b);
        end
      endcase
    end else begin
      repeat ($urandom_range(1, 6)) begin
        b = $urandom_range(0, 255);
        chunk.push_back(b);
      end
    end
  endfunction

  // ---------------------------------------------------------------- tests

  // Foreground plus bright background set by one SGR
  task automatic test_sgr_colors();
    add_csi_open();
    add_number(31, 1'b0);
    chunk.push_back(CH_SEP);
    add_number(104, 1'b0);
    chunk.push_back(CH_SGR);
    send_chunk();
  endtask

  // Lowest and highest byte, top of the font, newline
  task automatic test_glyph_bounds();
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'h7F);
    send_byte(CH_NL);
  endtask

  // Escape not followed by a bracket drops that byte
  task automatic test_escape_abort();
    send_byte(CH_ESC);
    send_byte(CH_ABORT);
    send_byte(CH_LETTER);
  endtask

  // Saturated row clamps to the bottom; zero column means column 1; newline scrolls
  task automatic test_cursor_position();
    add_csi_open();
    add_number(9999, 1'b0);
    chunk.push_back(CH_SEP);
    chunk.push_back(CH_ZERO);
    chunk.push_back(CH_CUP);
    chunk.push_back(CH_LETTER);
    chunk.push_back(CH_NL);
    send_chunk();
  endtask

  // Bare SGR restores default colors
  task automatic test_sgr_reset();
    add_csi_open();
    chunk.push_back(CH_SGR);
    chunk.push_back(CH_LETTER);
    send_chunk();
  endtask

  // New screen geometry, then random console text with one full drain midway
  task automatic test_screen_setting(input int cols, input int rows, input int glyph_max,
                                     input int scroll, input int items);
    int sent;
    bit paused;
    sent = 0;
    paused = 0;
    wait_drained();
    write_reg(REG_TEXT_COLUMNS, cols);
    write_reg(REG_TEXT_ROWS, rows);
    write_reg(REG_HIGHEST_GLYPH, glyph_max);
    write_reg(REG_SCROLL_LINES, scroll);
    sender_steady = ($urandom_range(0, 2) == 0);
    while (sent < items) begin
      build_chunk();
      sent += chunk.size();
      send_chunk();
      if (!paused && sent >= items / 2) begin
        paused = 1;
        wait_drained();
        sender_steady = !sender_steady;
      end
    end
  endtask

  initial begin
    rst_n         <= 1'b0;
    in_ch.valid   <= 1'b0;
    in_ch.in_byte <= 8'h00;
    psel          <= 1'b0;
    penable       <= 1'b0;
    pwrite        <= 1'b0;
    paddr         <= '0;
    pwdata        <= '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_sgr_colors();
    test_glyph_bounds();
    test_escape_abort();
    test_cursor_position();
    test_sgr_reset();

    // one-cell screen: every glyph wraps and scrolls; zero scroll clamps to one row
    test_screen_setting(1, 1, 0, 0, 90);
    test_screen_setting(256, 128, 255, 128, 110);
    // raw register maxima clamp to the screen limits
    test_screen_setting(511, 255, 128, 255, 90);
    // zero sizes clamp to one; the cursor left far off screen gets pulled back
    test_screen_setting(0, 0, 255, 1, 70);
    test_screen_setting($urandom_range(2, 8), $urandom_range(2, 5), $urandom_range(0, 255),
                        $urandom_range(1, 6), 110);
    test_screen_setting(RST_TEXT_COLUMNS, RST_TEXT_ROWS, RST_HIGHEST_GLYPH,
                        RST_SCROLL_LINES, 100);

    wait_drained();
    if (mismatch_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/atcp_pkg.sv
rtl/atcp_if.sv
rtl/atcp_core.sv
rtl/atcp_outq.sv
rtl/ansi_text_console_parser_unit.sv
tb/sv/ansi_text_console_parser_unit_tb.sv
